// ===== src/lep_pkg.sv =====
// Shared types, constants and helpers for the leftmost-entry pivot search block.
package lep_pkg;

   localparam int unsigned COLUMNS_DEFAULT = 1024;
   localparam int unsigned ROWS_DEFAULT    = 65536;

   localparam int unsigned COL_W = 10;
   localparam int unsigned ROW_W = 16;
   localparam int unsigned CNT_W = 11;
   localparam int unsigned OFF_W = 10;

   localparam logic [CNT_W-1:0] SAT_COUNT  = 11'd2047;
   localparam logic [OFF_W-1:0] SAT_OFFSET = 10'd1023;

   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic             is_query;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic [OFF_W-1:0] offset;
      logic [CNT_W-1:0] weight;
   } op_type;

   typedef struct packed {
      logic             is_query_reply;
      logic             pivot_taken;
      logic [COL_W-1:0] pivot_column;
      logic [OFF_W-1:0] pivot_offset;
      logic             has_pivot;
      logic [ROW_W-1:0] pivot_row;
      logic [CNT_W-1:0] pivot_count;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_EVAL
   } back_state_type;

   // Remainder by an elaboration-time constant, by restoring compare-subtract.
   function automatic logic [15:0] mod_const(input logic [15:0] value,
                                             input int unsigned divisor);
      logic [31:0] rem;
      logic [31:0] step;
      rem = {16'd0, value};
      for (int k = 15; k >= 0; k--) begin
         step = 32'(divisor) << k;
         if (divisor < 32'd65536 && step <= 32'd65535 && rem >= step) begin
            rem = rem - step;
         end
      end
      return rem[15:0];
   endfunction

endpackage

// ===== src/lep_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lep_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lep_queue.sv =====
// Short queue of classified operations between front and back.
module lep_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  lep_pkg::op_type          push_data,
   input  logic                     pop,
   output lep_pkg::op_type          pop_data,
   output lep_pkg::queue_status_type status
);

   localparam int unsigned QAW = $clog2(lep_pkg::QUEUE_DEPTH);
   localparam int unsigned QCW = $clog2(lep_pkg::QUEUE_DEPTH + 1);

   lep_pkg::op_type  slot_ff [lep_pkg::QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == QCW'(lep_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/lep_front.sv =====
// Front end: reduces indices, tracks the running leftmost entry, emits row ends and queries.
module lep_front #(
   parameter int unsigned COLUMNS = lep_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = lep_pkg::ROWS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        command,
   input  logic [lep_pkg::COL_W-1:0]   column,
   input  logic [lep_pkg::ROW_W-1:0]   row_index,
   input  logic                        last_in_row,
   output logic                        op_push,
   output lep_pkg::op_type             op_data
);

   logic [lep_pkg::COL_W-1:0] col_red;
   logic [lep_pkg::ROW_W-1:0] row_red;
   logic [lep_pkg::COL_W-1:0] min_col_ff, min_col_in;
   logic [lep_pkg::OFF_W-1:0] min_off_ff, min_off_in;
   logic [lep_pkg::CNT_W-1:0] seen_ff, seen_in;
   logic [lep_pkg::COL_W-1:0] upd_col;
   logic [lep_pkg::OFF_W-1:0] upd_off;
   logic [lep_pkg::CNT_W-1:0] upd_seen;
   logic                      is_entry;

   assign col_red = lep_pkg::COL_W'(lep_pkg::mod_const(16'(column), COLUMNS));
   assign row_red = lep_pkg::mod_const(row_index, ROWS);
   assign is_entry = accept && !command;

   always_comb begin
      upd_col = min_col_ff;
      upd_off = min_off_ff;
      if (seen_ff == '0 || col_red < min_col_ff) begin
         upd_col = col_red;
         upd_off = (seen_ff > lep_pkg::CNT_W'(lep_pkg::SAT_OFFSET))
                   ? lep_pkg::SAT_OFFSET : seen_ff[lep_pkg::OFF_W-1:0];
      end
      upd_seen = (seen_ff < lep_pkg::SAT_COUNT) ? seen_ff + 1'b1 : seen_ff;

      min_col_in = min_col_ff;
      min_off_in = min_off_ff;
      seen_in    = seen_ff;
      if (is_entry) begin
         if (last_in_row) begin
            min_col_in = '0;
            min_off_in = '0;
            seen_in    = '0;
         end else begin
            min_col_in = upd_col;
            min_off_in = upd_off;
            seen_in    = upd_seen;
         end
      end
   end

   always_comb begin
      op_push          = accept && (command || last_in_row);
      op_data.is_query = command;
      op_data.column   = command ? col_red : upd_col;
      op_data.row      = row_red;
      op_data.offset   = command ? '0 : upd_off;
      op_data.weight   = upd_seen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_col_ff <= '0;
         min_off_ff <= '0;
         seen_ff    <= '0;
      end else begin
         min_col_ff <= min_col_in;
         min_off_ff <= min_off_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

// ===== src/lep_back.sv =====
// Back end: pivot table clear, read-modify-write per row end, query lookup, result register.
module lep_back #(
   parameter int unsigned TABLE_DEPTH = lep_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROW_SW      = lep_pkg::ROW_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  lep_pkg::op_type      q_data,
   output logic                 q_pop,
   output logic                 clearing,
   output logic                 out_valid,
   output lep_pkg::rsp_type     out_data,
   input  logic                 out_pop
);

   localparam int unsigned TAW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned ENTRY_W = 1 + lep_pkg::CNT_W + ROW_SW;

   lep_pkg::back_state_type   state_ff, state_in;
   logic [TAW-1:0]            clear_addr_ff, clear_addr_in;
   lep_pkg::op_type           op_ff;
   logic [lep_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      out_valid_ff, out_valid_in;
   lep_pkg::rsp_type          out_ff, out_in;

   logic                      wr_en, rd_en;
   logic [TAW-1:0]            wr_addr, rd_addr;
   logic [ENTRY_W-1:0]        wr_data, rd_data;
   logic                      st_valid;
   logic [lep_pkg::CNT_W-1:0] st_weight;
   logic [ROW_SW-1:0]         st_row;
   logic                      taken, out_free, fire;

   lep_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign st_valid  = rd_data[ENTRY_W-1];
   assign st_weight = rd_data[ENTRY_W-2 -: lep_pkg::CNT_W];
   assign st_row    = rd_data[ROW_SW-1:0];
   assign taken     = !st_valid || (op_ff.weight < st_weight);
   assign out_free  = !out_valid_ff || out_pop;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lep_pkg::BACK_CLEAR: begin
            if (clear_addr_ff == TAW'(TABLE_DEPTH - 1)) begin
               state_in = lep_pkg::BACK_IDLE;
            end
         end
         lep_pkg::BACK_IDLE: begin
            if (!q_empty) begin
               state_in = lep_pkg::BACK_EVAL;
            end
         end
         lep_pkg::BACK_EVAL: begin
            if (out_free) begin
               state_in = lep_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = lep_pkg::BACK_CLEAR;
         end
      endcase
   end

   always_comb begin
      clearing      = 1'b0;
      q_pop         = 1'b0;
      fire          = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = q_data.column[TAW-1:0];
      wr_en         = 1'b0;
      wr_addr       = op_ff.column[TAW-1:0];
      wr_data       = {1'b1, op_ff.weight, op_ff.row[ROW_SW-1:0]};
      clear_addr_in = clear_addr_ff;
      case (state_ff)
         lep_pkg::BACK_CLEAR: begin
            clearing      = 1'b1;
            wr_en         = 1'b1;
            wr_addr       = clear_addr_ff;
            wr_data       = '0;
            clear_addr_in = clear_addr_ff + 1'b1;
         end
         lep_pkg::BACK_IDLE: begin
            q_pop = !q_empty;
            rd_en = !q_empty;
         end
         lep_pkg::BACK_EVAL: begin
            fire  = out_free;
            wr_en = out_free && !op_ff.is_query && taken;
         end
         default: begin
            clearing = 1'b1;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (fire && !op_ff.is_query && !st_valid && count_ff < lep_pkg::SAT_COUNT) begin
         count_in = count_ff + 1'b1;
      end

      out_in = out_ff;
      if (fire) begin
         out_in.is_query_reply = op_ff.is_query;
         out_in.pivot_column   = op_ff.column;
         out_in.pivot_count    = count_in;
         if (op_ff.is_query) begin
            out_in.pivot_taken  = 1'b0;
            out_in.pivot_offset = '0;
            out_in.has_pivot    = st_valid;
            out_in.pivot_row    = st_valid ? lep_pkg::ROW_W'(st_row) : '0;
         end else begin
            out_in.pivot_taken  = taken;
            out_in.pivot_offset = op_ff.offset;
            out_in.has_pivot    = 1'b1;
            out_in.pivot_row    = taken ? lep_pkg::ROW_W'(op_ff.row[ROW_SW-1:0])
                                        : lep_pkg::ROW_W'(st_row);
         end
      end

      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (out_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lep_pkg::BACK_CLEAR;
         clear_addr_ff <= '0;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff <= q_data;
      end
      out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

// ===== src/leftmost_entry_pivot_search.sv =====
// Top level of the leftmost-entry pivot search block.
//
//   channel   direction  transfer when        payload
//   req_      in         req_push & !full    command, column, row_index, last_in_row
//   rsp_      out        rsp_pop & !empty    reply, taken, column, offset, pivot, row, count
//
// The front takes one entry per cycle while req_full is low; each row end or query then
// goes through the back one at a time (table read, then update and result).
// A short queue lets runs of plain entries flow while the back works on a row end.
// After reset a clearing pass writes every table entry, one per cycle, up to the table depth
// (1024 by default); req_full stays high during it.
// rsp_ holds one result in a register; a stalled rsp_pop backs up into the queue.
module leftmost_entry_pivot_search #(
   parameter int unsigned COLUMNS = lep_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = lep_pkg::ROWS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_command,
   input  logic [lep_pkg::COL_W-1:0] req_column,
   input  logic [lep_pkg::ROW_W-1:0] req_row_index,
   input  logic                      req_last_in_row,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_is_query_reply,
   output logic                      rsp_pivot_taken,
   output logic [lep_pkg::COL_W-1:0] rsp_pivot_column,
   output logic [lep_pkg::OFF_W-1:0] rsp_pivot_offset,
   output logic                      rsp_has_pivot,
   output logic [lep_pkg::ROW_W-1:0] rsp_pivot_row,
   output logic [lep_pkg::CNT_W-1:0] rsp_pivot_count
);

   localparam int unsigned TABLE_DEPTH = (COLUMNS < 1024) ? COLUMNS : 1024;
   localparam int unsigned ROW_SW      = (ROWS >= 65536) ? 16 : $clog2(ROWS);

   logic                      accept;
   logic                      op_push;
   lep_pkg::op_type           op_in, op_out;
   logic                      op_pop;
   lep_pkg::queue_status_type q_status;
   logic                      clearing;
   logic                      out_valid;
   lep_pkg::rsp_type          out_data;

   assign req_full = clearing || q_status.full;
   assign accept   = req_push && !req_full;

   lep_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .command     (req_command),
      .column      (req_column),
      .row_index   (req_row_index),
      .last_in_row (req_last_in_row),
      .op_push     (op_push),
      .op_data     (op_in)
   );

   lep_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_in),
      .pop       (op_pop),
      .pop_data  (op_out),
      .status    (q_status)
   );

   lep_back #(.TABLE_DEPTH(TABLE_DEPTH), .ROW_SW(ROW_SW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_status.empty),
      .q_data    (op_out),
      .q_pop     (op_pop),
      .clearing  (clearing),
      .out_valid (out_valid),
      .out_data  (out_data),
      .out_pop   (rsp_pop)
   );

   assign rsp_empty          = !out_valid;
   assign rsp_is_query_reply = out_data.is_query_reply;
   assign rsp_pivot_taken    = out_data.pivot_taken;
   assign rsp_pivot_column   = out_data.pivot_column;
   assign rsp_pivot_offset   = out_data.pivot_offset;
   assign rsp_has_pivot      = out_data.has_pivot;
   assign rsp_pivot_row      = out_data.pivot_row;
   assign rsp_pivot_count    = out_data.pivot_count;

endmodule
